@@ design/tlg_pkg.sv @@
// Package for the two-list ghost cache policy block.
// Sizes, list control struct, FSM states, hit-list and register codes. No dependencies.
`timescale 1ns / 1ps
package tlg_pkg;
  localparam int MAX_ENTRIES       = 64;
  localparam int MAX_GHOST_ENTRIES = 256;
  localparam int KEY_BITS          = 32;
  localparam int CAP_W             = 7;
  localparam int FAC_W             = 3;
  localparam int LIM_W             = CAP_W + FAC_W;
  localparam int RES_CELLS         = MAX_ENTRIES + 1;
  localparam int GH_CELLS          = MAX_GHOST_ENTRIES + 1;
  localparam int RES_W             = $clog2(RES_CELLS + 1);
  localparam int GH_W              = $clog2(GH_CELLS + 1);

  localparam logic CFG_CAPACITY    = 1'b0;
  localparam logic CFG_FACTOR      = 1'b1;

  // del: remove one entry (at zero or at the found index), load: append key
  typedef struct packed {
    logic find;
    logic del;
    logic at_zero;
    logic load;
  } lop_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cctl_t;

  typedef enum logic [1:0] {
    HL_MISS   = 2'd0,
    HL_RECENT = 2'd1,
    HL_FREQ   = 2'd2
  } hl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIND,
    ST_ACT,
    ST_EVICT,
    ST_GFIND,
    ST_GADD,
    ST_DONE
  } state_t;
endpackage

@@ design/two_list_ghost_cache_policy_top.sv @@
// Top level: request FSM over two resident and two ghost cell-chain lists.
// Depends on tlg_pkg, tlg_res_list, tlg_ghost_list.
// Sequence: find, update and done on a hit or a plain miss; a miss that evicts
// also passes evict, ghost find and ghost add. The result strobe is registered from done.
// A new transaction is taken only in idle, while busy is low; start is taken in the strobe cycle.
// The receiver cannot stall. Reset empties all lists, capacity 64, ghost factor 1.
`timescale 1ns / 1ps
module two_list_ghost_cache_policy_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [tlg_pkg::KEY_BITS-1:0] in_object_key,
  output logic                         out_strobe,
  output logic                         out_hit,
  output logic [1:0]                   out_hit_list,
  output logic                         out_evicted_valid,
  output logic [tlg_pkg::KEY_BITS-1:0] out_evicted_key,
  output logic [tlg_pkg::CAP_W-1:0]    out_resident_count,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic                         cfg_index,
  input  logic [tlg_pkg::CAP_W-1:0]    cfg_data
);
  localparam int RW = tlg_pkg::RES_W;
  localparam int GW = tlg_pkg::GH_W;
  localparam int LW = tlg_pkg::LIM_W;

  tlg_pkg::state_t              state_r, state_nxt;
  logic [tlg_pkg::CAP_W-1:0]    cap_r;
  logic [tlg_pkg::FAC_W-1:0]    fac_r;
  logic [tlg_pkg::KEY_BITS-1:0] key_r, evk_r, evk_nxt;
  logic                         hit_r, hit_nxt, evv_r, evv_nxt, tgt_r, tgt_nxt;
  tlg_pkg::hl_t                 hl_r, hl_nxt;
  logic                         strobe_r, ohit_r, oevv_r;
  logic [1:0]                   ohl_r;
  logic [tlg_pkg::KEY_BITS-1:0] oevk_r;
  logic [tlg_pkg::CAP_W-1:0]    ores_r;

  tlg_pkg::lop_t                rop, fop, rgop, fgop;
  logic [tlg_pkg::KEY_BITS-1:0] cmp_key, g_ld_key;
  logic                         r_fnd, f_fnd, rg_fnd, fg_fnd;
  logic [RW-1:0]                r_cnt, f_cnt;
  logic [GW-1:0]                rg_cnt, fg_cnt, tg_cnt;
  logic [tlg_pkg::KEY_BITS-1:0] r_old, f_old;
  logic [RW-1:0]                ecap;
  logic [tlg_pkg::FAC_W-1:0]    efac;
  logic [LW-1:0]                prod;
  logic [GW-1:0]                lim;
  logic                         tg_fnd;
  logic [RW:0]                  total;

  always_comb begin
    if (cap_r == '0) ecap = RW'(1);
    else if (RW'(cap_r) > RW'(tlg_pkg::MAX_ENTRIES)) ecap = RW'(tlg_pkg::MAX_ENTRIES);
    else ecap = RW'(cap_r);
    efac = (fac_r == '0) ? tlg_pkg::FAC_W'(1) : fac_r;
    prod = LW'(ecap) * LW'(efac);
    lim  = (prod > LW'(tlg_pkg::MAX_GHOST_ENTRIES)) ? GW'(tlg_pkg::MAX_GHOST_ENTRIES)
                                                     : GW'(prod);
  end

  assign total    = {1'b0, r_cnt} + {1'b0, f_cnt} + (RW+1)'(1);
  assign tg_cnt   = tgt_r ? fg_cnt : rg_cnt;
  assign tg_fnd   = tgt_r ? fg_fnd : rg_fnd;
  assign cmp_key  = (state_r == tlg_pkg::ST_GFIND) ? evk_r : key_r;
  assign g_ld_key = evk_r;

  tlg_res_list u_rec (
    .clk(clk), .rst_n(rst_n), .op(rop), .cmp_key(cmp_key), .ld_key(key_r),
    .found(r_fnd), .count(r_cnt), .oldest(r_old)
  );
  tlg_res_list u_frq (
    .clk(clk), .rst_n(rst_n), .op(fop), .cmp_key(cmp_key), .ld_key(key_r),
    .found(f_fnd), .count(f_cnt), .oldest(f_old)
  );
  tlg_ghost_list u_rgh (
    .clk(clk), .rst_n(rst_n), .op(rgop), .cmp_key(cmp_key), .ld_key(g_ld_key),
    .found(rg_fnd), .count(rg_cnt)
  );
  tlg_ghost_list u_fgh (
    .clk(clk), .rst_n(rst_n), .op(fgop), .cmp_key(cmp_key), .ld_key(g_ld_key),
    .found(fg_fnd), .count(fg_cnt)
  );

  always_comb begin
    tlg_pkg::lop_t gop;
    state_nxt = state_r;
    rop       = '0;
    fop       = '0;
    rgop      = '0;
    fgop      = '0;
    gop       = '0;
    hit_nxt   = hit_r;
    hl_nxt    = hl_r;
    evv_nxt   = evv_r;
    evk_nxt   = evk_r;
    tgt_nxt   = tgt_r;
    unique case (state_r)
      tlg_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = tlg_pkg::ST_FIND;
          hit_nxt   = 1'b0;
          hl_nxt    = tlg_pkg::HL_MISS;
          evv_nxt   = 1'b0;
          evk_nxt   = '0;
        end
      end
      tlg_pkg::ST_FIND: begin
        rop.find  = 1'b1;
        fop.find  = 1'b1;
        rgop.find = 1'b1;
        fgop.find = 1'b1;
        state_nxt = tlg_pkg::ST_ACT;
      end
      tlg_pkg::ST_ACT: begin
        state_nxt = tlg_pkg::ST_DONE;
        if (r_fnd) begin
          rop.del  = 1'b1;
          fop.load = 1'b1;
          hit_nxt  = 1'b1;
          hl_nxt   = tlg_pkg::HL_RECENT;
        end else if (f_fnd) begin
          fop.del  = 1'b1;
          fop.load = 1'b1;
          hit_nxt  = 1'b1;
          hl_nxt   = tlg_pkg::HL_FREQ;
        end else begin
          rop.load = 1'b1;
          if (total > {1'b0, ecap}) state_nxt = tlg_pkg::ST_EVICT;
        end
      end
      tlg_pkg::ST_EVICT: begin
        evv_nxt   = 1'b1;
        state_nxt = tlg_pkg::ST_GFIND;
        if (rg_fnd) begin
          rgop.del = 1'b1;
          if (f_cnt != '0) begin
            fop.del     = 1'b1;
            fop.at_zero = 1'b1;
            evk_nxt     = f_old;
            tgt_nxt     = 1'b1;
          end else begin
            rop.del     = 1'b1;
            rop.at_zero = 1'b1;
            evk_nxt     = r_old;
            tgt_nxt     = 1'b0;
          end
        end else begin
          if (fg_fnd) fgop.del = 1'b1;
          rop.del     = 1'b1;
          rop.at_zero = 1'b1;
          evk_nxt     = r_old;
          tgt_nxt     = 1'b0;
        end
      end
      tlg_pkg::ST_GFIND: begin
        gop.find  = 1'b1;
        state_nxt = tlg_pkg::ST_GADD;
        if (tgt_r) fgop = gop;
        else rgop = gop;
      end
      tlg_pkg::ST_GADD: begin
        gop.load  = 1'b1;
        state_nxt = tlg_pkg::ST_DONE;
        if (tg_fnd) begin
          gop.del = 1'b1;
        end else if (tg_cnt >= lim) begin
          gop.del     = 1'b1;
          gop.at_zero = 1'b1;
        end
        if (tgt_r) fgop = gop;
        else rgop = gop;
      end
      tlg_pkg::ST_DONE: begin
        state_nxt = tlg_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = tlg_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= tlg_pkg::ST_IDLE;
      cap_r    <= tlg_pkg::CAP_W'(tlg_pkg::MAX_ENTRIES);
      fac_r    <= tlg_pkg::FAC_W'(1);
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= (state_r == tlg_pkg::ST_DONE);
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == tlg_pkg::CFG_CAPACITY) cap_r <= cfg_data;
        else fac_r <= cfg_data[tlg_pkg::FAC_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    hit_r <= hit_nxt;
    hl_r  <= hl_nxt;
    evv_r <= evv_nxt;
    evk_r <= evk_nxt;
    tgt_r <= tgt_nxt;
    if (state_r == tlg_pkg::ST_IDLE && start) key_r <= in_object_key;
    if (state_r == tlg_pkg::ST_DONE) begin
      ohit_r <= hit_r;
      ohl_r  <= hl_r;
      oevv_r <= evv_r;
      oevk_r <= evk_r;
      ores_r <= tlg_pkg::CAP_W'(r_cnt + f_cnt);
    end
  end

  assign busy               = (state_r != tlg_pkg::ST_IDLE);
  assign cfg_ready          = 1'b1;
  assign out_strobe         = strobe_r;
  assign out_hit            = ohit_r;
  assign out_hit_list       = ohl_r;
  assign out_evicted_valid  = oevv_r;
  assign out_evicted_key    = oevk_r;
  assign out_resident_count = ores_r;
endmodule

@@ design/tlg_cell.sv @@
// One list cell: a key, a valid bit and a key comparator.
// Takes its upper neighbor's entry on shift. Depends on tlg_pkg.
`timescale 1ns / 1ps
module tlg_cell (
  input  logic                         clk,
  input  logic                         rst_n,
  input  tlg_pkg::cctl_t               ctl,
  input  logic [tlg_pkg::KEY_BITS-1:0] up_key,
  input  logic                         up_vld,
  input  logic [tlg_pkg::KEY_BITS-1:0] ld_key,
  input  logic [tlg_pkg::KEY_BITS-1:0] cmp_key,
  output logic [tlg_pkg::KEY_BITS-1:0] key,
  output logic                         vld,
  output logic                         match
);
  logic [tlg_pkg::KEY_BITS-1:0] key_r;
  logic                         vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ctl.load) begin
      vld_r <= 1'b1;
    end else if (ctl.shift) begin
      vld_r <= up_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      key_r <= ld_key;
    end else if (ctl.shift) begin
      key_r <= up_key;
    end
  end

  assign key   = key_r;
  assign vld   = vld_r;
  assign match = vld_r && (key_r == cmp_key);
endmodule

@@ design/tlg_res_list.sv @@
// Resident LRU list as a chain of cells, oldest in cell 0.
// Registered find, remove with shift-down, append at tail. Depends on tlg_pkg, tlg_cell.
`timescale 1ns / 1ps
module tlg_res_list (
  input  logic                         clk,
  input  logic                         rst_n,
  input  tlg_pkg::lop_t                op,
  input  logic [tlg_pkg::KEY_BITS-1:0] cmp_key,
  input  logic [tlg_pkg::KEY_BITS-1:0] ld_key,
  output logic                         found,
  output logic [tlg_pkg::RES_W-1:0]    count,
  output logic [tlg_pkg::KEY_BITS-1:0] oldest
);
  localparam int N = tlg_pkg::RES_CELLS;
  localparam int W = tlg_pkg::RES_W;

  logic [tlg_pkg::KEY_BITS-1:0] key_a [N];
  logic [N-1:0]                 vld_a;
  logic [N-1:0]                 match_a;
  logic [W-1:0]                 cnt_r, cnt_nxt;
  logic [W-1:0]                 idx_r, idx_c, del_pos, ld_pos;
  logic                         found_r;

  always_comb begin
    idx_c = '0;
    for (int j = 0; j < N; j++) begin
      if (match_a[j]) idx_c = idx_c | W'(j);
    end
  end

  assign del_pos = op.at_zero ? '0 : idx_r;
  assign ld_pos  = cnt_r - W'(op.del);
  assign cnt_nxt = cnt_r + W'(op.load) - W'(op.del);

  for (genvar j = 0; j < N; j++) begin : g_cell
    tlg_pkg::cctl_t               ctl;
    logic [tlg_pkg::KEY_BITS-1:0] up_key;
    logic                         up_vld;
    assign ctl.load  = op.load && (ld_pos == W'(j));
    assign ctl.shift = op.del && (W'(j) >= del_pos);
    if (j == N - 1) begin : g_top
      assign up_key = '0;
      assign up_vld = 1'b0;
    end else begin : g_mid
      assign up_key = key_a[j+1];
      assign up_vld = vld_a[j+1];
    end
    tlg_cell u_cell (
      .clk(clk), .rst_n(rst_n), .ctl(ctl), .up_key(up_key), .up_vld(up_vld),
      .ld_key(ld_key), .cmp_key(cmp_key), .key(key_a[j]), .vld(vld_a[j]),
      .match(match_a[j])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      found_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (op.find) found_r <= |match_a;
    end
  end

  always_ff @(posedge clk) begin
    if (op.find) idx_r <= idx_c;
  end

  assign found  = found_r;
  assign count  = cnt_r;
  assign oldest = key_a[0];
endmodule

@@ design/tlg_ghost_list.sv @@
// Ghost LRU list as a chain of cells, oldest in cell 0.
// Registered find, remove with shift-down, append at tail. Depends on tlg_pkg, tlg_cell.
`timescale 1ns / 1ps
module tlg_ghost_list (
  input  logic                         clk,
  input  logic                         rst_n,
  input  tlg_pkg::lop_t                op,
  input  logic [tlg_pkg::KEY_BITS-1:0] cmp_key,
  input  logic [tlg_pkg::KEY_BITS-1:0] ld_key,
  output logic                         found,
  output logic [tlg_pkg::GH_W-1:0]     count
);
  localparam int N = tlg_pkg::GH_CELLS;
  localparam int W = tlg_pkg::GH_W;

  logic [tlg_pkg::KEY_BITS-1:0] key_a [N];
  logic [N-1:0]                 vld_a;
  logic [N-1:0]                 match_a;
  logic [W-1:0]                 cnt_r, cnt_nxt;
  logic [W-1:0]                 idx_r, idx_c, del_pos, ld_pos;
  logic                         found_r;

  always_comb begin
    idx_c = '0;
    for (int j = 0; j < N; j++) begin
      if (match_a[j]) idx_c = idx_c | W'(j);
    end
  end

  assign del_pos = op.at_zero ? '0 : idx_r;
  assign ld_pos  = cnt_r - W'(op.del);
  assign cnt_nxt = cnt_r + W'(op.load) - W'(op.del);

  for (genvar j = 0; j < N; j++) begin : g_cell
    tlg_pkg::cctl_t               ctl;
    logic [tlg_pkg::KEY_BITS-1:0] up_key;
    logic                         up_vld;
    assign ctl.load  = op.load && (ld_pos == W'(j));
    assign ctl.shift = op.del && (W'(j) >= del_pos);
    if (j == N - 1) begin : g_top
      assign up_key = '0;
      assign up_vld = 1'b0;
    end else begin : g_mid
      assign up_key = key_a[j+1];
      assign up_vld = vld_a[j+1];
    end
    tlg_cell u_cell (
      .clk(clk), .rst_n(rst_n), .ctl(ctl), .up_key(up_key), .up_vld(up_vld),
      .ld_key(ld_key), .cmp_key(cmp_key), .key(key_a[j]), .vld(vld_a[j]),
      .match(match_a[j])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      found_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (op.find) found_r <= |match_a;
    end
  end

  always_ff @(posedge clk) begin
    if (op.find) idx_r <= idx_c;
  end

  assign found = found_r;
  assign count = cnt_r;
endmodule
